/* design/bdd_ut_pkg.sv */
// ----------------------------------------------------------------------------
// bdd_ut_pkg
// Shared types and constants for the decision-diagram unique table.
// ----------------------------------------------------------------------------
`default_nettype none

package bdd_ut_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ID_W        = 32;
    localparam int KEY_W       = 32;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int FILL_W      = 11;
    localparam int CMP_W       = (CNT_W > FILL_W) ? CNT_W : FILL_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);

    localparam logic [FILL_W-1:0] FILL_RESET = FILL_W'(768);

    localparam logic [1:0] OUT_EQUAL    = 2'd0;
    localparam logic [1:0] OUT_FOUND    = 2'd1;
    localparam logic [1:0] OUT_INSERTED = 2'd2;
    localparam logic [1:0] OUT_FULL     = 2'd3;

    // one classified request waiting for the probe engine
    typedef struct packed {
        logic              is_equal;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   low;
        logic [ID_W-1:0]   high;
        logic [ID_W-1:0]   spare;
    } t_req;

    // one table slot
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] low;
        logic [ID_W-1:0] high;
        logic [ID_W-1:0] node;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

`default_nettype wire

/* design/bdd_ut_front.sv */
// ----------------------------------------------------------------------------
// bdd_ut_front
// Accepts requests, flags equal children and hashes the start slot.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_ut_front (
    input  wire logic                    start,
    input  wire logic [bdd_ut_pkg::ID_W-1:0]  i_low_child,
    input  wire logic [bdd_ut_pkg::ID_W-1:0]  i_high_child,
    input  wire logic [bdd_ut_pkg::KEY_W-1:0] i_low_key,
    input  wire logic [bdd_ut_pkg::KEY_W-1:0] i_high_key,
    input  wire logic [bdd_ut_pkg::ID_W-1:0]  i_spare_id,
    input  wire bdd_ut_pkg::t_q_stat          i_q_stat,
    input  wire logic                    i_clearing,
    output logic                         busy,
    output logic                         o_push,
    output bdd_ut_pkg::t_req             o_req
);
    import bdd_ut_pkg::*;

    logic [KEY_W-1:0] hash;

    // low_key xor twice high_key
    assign hash = i_low_key ^ {i_high_key[KEY_W-2:0], 1'b0};

    assign busy   = i_q_stat.full | i_clearing;
    assign o_push = start & ~busy;

    always_comb begin
        o_req.is_equal = (i_low_child == i_high_child);
        o_req.slot     = hash[SLOT_W-1:0];
        o_req.low      = i_low_child;
        o_req.high     = i_high_child;
        o_req.spare    = i_spare_id;
    end

endmodule

`default_nettype wire

/* design/bdd_ut_queue.sv */
// ----------------------------------------------------------------------------
// bdd_ut_queue
// Short request queue between the front end and the probe engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_ut_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bdd_ut_pkg::t_req i_data,
    input  wire logic             i_pop,
    output bdd_ut_pkg::t_req      o_data,
    output bdd_ut_pkg::t_q_stat   o_stat
);
    import bdd_ut_pkg::*;

    t_req              r_data [QUEUE_DEPTH];
    logic [QP_W-1:0]   r_wp;
    logic [QP_W-1:0]   r_rp;
    logic [QP_W:0]     r_cnt;
    logic              q_empty;
    logic              q_full;
    logic              do_push;
    logic              do_pop;

    assign q_empty = (r_cnt == '0);
    assign q_full  = (r_cnt == (QP_W+1)'(QUEUE_DEPTH));
    assign o_stat  = '{empty: q_empty, full: q_full};
    assign do_push = i_push & ~q_full;
    assign do_pop  = i_pop & ~q_empty;
    assign o_data  = r_data[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QP_W+1)'(do_push) - (QP_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* design/bdd_ut_back.sv */
// ----------------------------------------------------------------------------
// bdd_ut_back
// Probe engine: owns the slot memory, walks it linearly, inserts on a miss below the fill limit.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_ut_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [bdd_ut_pkg::FILL_W-1:0] i_fill_limit,
    input  wire bdd_ut_pkg::t_q_stat           i_q_stat,
    input  wire bdd_ut_pkg::t_req              i_req,
    output logic                               o_pop,
    output logic                               o_clearing,
    output logic                               o_done,
    output logic [bdd_ut_pkg::ID_W-1:0]        o_result_id,
    output logic [1:0]                         o_outcome
);
    import bdd_ut_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;

    t_entry            r_mem [TABLE_DEPTH];
    t_entry            r_rd_data;

    logic [1:0]        r_state,   n_state;
    logic [SLOT_W-1:0] r_clr_addr, n_clr_addr;
    logic [SLOT_W-1:0] r_slot,    n_slot;
    logic [SLOT_W-1:0] r_probes,  n_probes;
    logic [CNT_W-1:0]  r_count,   n_count;
    logic [ID_W-1:0]   r_low,     n_low;
    logic [ID_W-1:0]   r_high,    n_high;
    logic [ID_W-1:0]   r_spare,   n_spare;
    logic              r_done,    n_done;
    logic [ID_W-1:0]   r_res_id,  n_res_id;
    logic [1:0]        r_outcome, n_outcome;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    t_entry            wr_data;
    logic [SLOT_W-1:0] rd_addr;
    logic              hit;
    logic              at_limit;

    assign hit      = r_rd_data.valid && (r_rd_data.low == r_low)
                      && (r_rd_data.high == r_high);
    assign at_limit = CMP_W'(r_count) >= CMP_W'(i_fill_limit);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_slot     = r_slot;
        n_probes   = r_probes;
        n_count    = r_count;
        n_low      = r_low;
        n_high     = r_high;
        n_spare    = r_spare;
        n_done     = 1'b0;
        n_res_id   = r_res_id;
        n_outcome  = r_outcome;
        o_pop      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_slot;
        wr_data.valid = 1'b1;
        wr_data.low   = r_low;
        wr_data.high  = r_high;
        wr_data.node  = r_spare;
        rd_addr    = r_slot + 1'b1;

        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    if (i_req.is_equal) begin
                        n_done    = 1'b1;
                        n_res_id  = i_req.low;
                        n_outcome = OUT_EQUAL;
                    end else begin
                        n_slot   = i_req.slot;
                        n_low    = i_req.low;
                        n_high   = i_req.high;
                        n_spare  = i_req.spare;
                        n_probes = '0;
                        rd_addr  = i_req.slot;
                        n_state  = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (!r_rd_data.valid) begin
                    // empty slot ends the walk
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                    if (at_limit) begin
                        n_res_id  = '0;
                        n_outcome = OUT_FULL;
                    end else begin
                        wr_en     = 1'b1;
                        n_count   = r_count + 1'b1;
                        n_res_id  = r_spare;
                        n_outcome = OUT_INSERTED;
                    end
                end else if (hit) begin
                    n_done    = 1'b1;
                    n_res_id  = r_rd_data.node;
                    n_outcome = OUT_FOUND;
                    n_state   = ST_IDLE;
                end else if (r_probes == '1) begin
                    // full pass without a free slot
                    n_done    = 1'b1;
                    n_res_id  = '0;
                    n_outcome = OUT_FULL;
                    n_state   = ST_IDLE;
                end else begin
                    n_slot   = r_slot + 1'b1;
                    n_probes = r_probes + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_count    <= n_count;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot    <= n_slot;
        r_probes  <= n_probes;
        r_low     <= n_low;
        r_high    <= n_high;
        r_spare   <= n_spare;
        r_res_id  <= n_res_id;
        r_outcome <= n_outcome;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_done      = r_done;
    assign o_result_id = r_res_id;
    assign o_outcome   = r_outcome;

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_outcome == OUT_INSERTED) |-> r_count == $past(r_count) + 1'b1)
        else $error("insert did not bump occupancy");

    a_other_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_outcome != OUT_INSERTED) |-> $stable(r_count))
        else $error("occupancy moved without an insert");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_stat.empty && r_state == ST_IDLE)
        else $error("pop from empty queue or while probing");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> !r_done)
        else $error("result during clearing pass");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(TABLE_DEPTH) || CMP_W'(r_count) == '0)
        else $error("occupancy beyond table depth");

endmodule

`default_nettype wire

/* design/bdd_unique_table_find_or_insert.sv */
// ----------------------------------------------------------------------------
// bdd_unique_table_find_or_insert
// Unique table for one decision-diagram variable: find or insert a node by
// its (low, high) children using a linearly probed hash table.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// request   in         start && !busy         i_low_child i_high_child
//                                             i_low_key i_high_key i_spare_id
// result    out        o_done (one cycle)     o_result_id o_outcome
// config    in         i_cfg_we               i_cfg_wdata (fill limit)
//
// equal children: the request passes the queue and the result is given without a probe.
// otherwise the request passes the queue, then slots are probed in turn before the result;
// the slot memory read port (one probe per cycle) sets the rate.
// after reset all TABLE_DEPTH (1024) slots are cleared; busy is high meanwhile.
// busy also rises while the two-entry request queue is full.
// the receiver cannot stall; each result strobe lasts one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_unique_table_find_or_insert (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [bdd_ut_pkg::ID_W-1:0]     i_low_child,
    input  wire logic [bdd_ut_pkg::ID_W-1:0]     i_high_child,
    input  wire logic [bdd_ut_pkg::KEY_W-1:0]    i_low_key,
    input  wire logic [bdd_ut_pkg::KEY_W-1:0]    i_high_key,
    input  wire logic [bdd_ut_pkg::ID_W-1:0]     i_spare_id,
    input  wire logic                            i_cfg_we,
    input  wire logic [bdd_ut_pkg::FILL_W-1:0]   i_cfg_wdata,
    output logic                                 o_done,
    output logic [bdd_ut_pkg::ID_W-1:0]          o_result_id,
    output logic [1:0]                           o_outcome
);
    import bdd_ut_pkg::*;

    logic [FILL_W-1:0] r_fill_limit;
    t_req              push_req;
    t_req              head_req;
    t_q_stat           q_stat;
    logic              push;
    logic              pop;
    logic              clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_limit <= FILL_RESET;
        end else if (i_cfg_we) begin
            r_fill_limit <= i_cfg_wdata;
        end
    end

    bdd_ut_front u_front (
        .start        (start),
        .i_low_child  (i_low_child),
        .i_high_child (i_high_child),
        .i_low_key    (i_low_key),
        .i_high_key   (i_high_key),
        .i_spare_id   (i_spare_id),
        .i_q_stat     (q_stat),
        .i_clearing   (clearing),
        .busy         (busy),
        .o_push       (push),
        .o_req        (push_req)
    );

    bdd_ut_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_req),
        .i_pop   (pop),
        .o_data  (head_req),
        .o_stat  (q_stat)
    );

    bdd_ut_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fill_limit (r_fill_limit),
        .i_q_stat     (q_stat),
        .i_req        (head_req),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_done       (o_done),
        .o_result_id  (o_result_id),
        .o_outcome    (o_outcome)
    );

endmodule

`default_nettype wire
